/* src/angd_pkg.sv */
// ----------------------------------------------------------------------------
// angd_pkg
// Shared types and constants of the angle growth hazard detector: field
// widths, the item and result records, configuration registers and states.
// ----------------------------------------------------------------------------
`default_nettype none

package angd_pkg;

   // Field widths fixed by the stream format.
   localparam int SOURCE_W = 2;
   localparam int TIME_W   = 32;
   localparam int ANGLE_W  = 17;
   localparam int CFG_W    = 16;

   // Product widths of the projection test.
   localparam int LHS_W = 33;
   localparam int RHS_W = 51;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WINDOW   = 2'd0;
   localparam logic [1:0] CSR_MIN_DT   = 2'd1;
   localparam logic [1:0] CSR_HORIZON  = 2'd2;
   localparam logic [1:0] CSR_CRITICAL = 2'd3;

   // Configuration reset values.
   localparam logic [CFG_W-1:0]          WINDOW_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0]          MIN_DT_RESET   = 16'd950;
   localparam logic [CFG_W-1:0]          HORIZON_RESET  = 16'd1000;
   localparam logic signed [ANGLE_W-1:0] CRITICAL_RESET = 17'sd34000;

   // Command codes on the input side.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // What the front decided an item is.
   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_CLEAR,
      KIND_IGNORE
   } item_kind_type;

   typedef struct packed {
      item_kind_type              kind;
      logic [SOURCE_W-1:0]        source;
      logic [TIME_W-1:0]          time_ms;
      logic signed [ANGLE_W-1:0]  angle;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0]          time_ms;
      logic signed [ANGLE_W-1:0]  angle;
   } point_type;

   typedef struct packed {
      logic                       hazard;
      logic [SOURCE_W-1:0]        hazard_source;
      logic signed [ANGLE_W-1:0]  current_angle;
      logic signed [ANGLE_W-1:0]  reference_angle;
      logic [TIME_W-1:0]          span_ms;
      logic                       history_overflow;
   } result_type;

   typedef struct packed {
      logic [CFG_W-1:0]           reference_window_ms;
      logic [CFG_W-1:0]           min_dt_ms;
      logic [CFG_W-1:0]           horizon_ms;
      logic signed [ANGLE_W-1:0]  critical_angle;
   } csr_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_CHECK,
      ST_SECOND,
      ST_REF,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

/* src/angle_growth_hazard_detector.sv */
// ----------------------------------------------------------------------------
// angle_growth_hazard_detector
// Per-source angle history with projected-growth hazard detection.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ stream: an angle sample (tuser 0) with source,
// timestamp and angle, or a clear command (tuser 1) that empties every
// history. Each item yields exactly one item on the rsp_ stream, in order.
// Registers are written on the csr_ channel, which is always ready; write
// them only while no item is in flight.
// In the back end a sample is stored in its source's ring, then aged points
// are dropped; each dropped point costs one read of the point memory and
// one compare. The oldest point left is the reference; the projection is
// tested only when the span and growth tests pass, and not at all when no
// reference point is left. A clear or an out-of-range sample skips all this.
// A two-entry queue sits between input and back end, so up to two items
// can be taken while the back end is busy. The result register holds a
// finished item while rsp_tready is low; the back end then waits and the
// queue fills, after which req_tready drops.
// Reset clears all histories and loads the register defaults; the point
// memory itself is not cleared, so the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_growth_hazard_detector #(
   parameter int SOURCES       = 4,
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [1:0] source, [33:2] time_ms, [50:34] angle, [55:51] zero
   input  wire logic [55:0]  req_tdata,
   // [0] command
   input  wire logic [0:0]   req_tuser,
   // Result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] hazard, [2:1] hazard_source, [19:3] current_angle,
   // [36:20] reference_angle, [68:37] span_ms, [69] history_overflow, [71:70] zero
   output logic [71:0]       rsp_tdata,
   // Configuration write channel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [16:0]  csr_data
);

   angd_pkg::csr_type    csr_ff, csr_in;
   logic                 q_valid;
   angd_pkg::item_type   q_item;
   logic                 q_pop;
   angd_pkg::result_type rsp;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            angd_pkg::CSR_WINDOW:   csr_in.reference_window_ms = csr_data[15:0];
            angd_pkg::CSR_MIN_DT:   csr_in.min_dt_ms           = csr_data[15:0];
            angd_pkg::CSR_HORIZON:  csr_in.horizon_ms          = csr_data[15:0];
            angd_pkg::CSR_CRITICAL: csr_in.critical_angle      = $signed(csr_data);
            default:                csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.reference_window_ms <= angd_pkg::WINDOW_RESET;
         csr_ff.min_dt_ms           <= angd_pkg::MIN_DT_RESET;
         csr_ff.horizon_ms          <= angd_pkg::HORIZON_RESET;
         csr_ff.critical_angle      <= angd_pkg::CRITICAL_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front end: accept, classify and queue.
   angd_front #(
      .SOURCES (SOURCES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end: history rings and projection test.
   angd_back #(
      .SOURCES       (SOURCES),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result.
   assign rsp_tdata = {2'b00, rsp.history_overflow, rsp.span_ms, rsp.reference_angle,
                       rsp.current_angle, rsp.hazard_source, rsp.hazard};

   // A result register is never left full across reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A hazard is only raised when the angle grew past the reference.
   a_hazard_growth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.hazard) |-> (rsp.current_angle > rsp.reference_angle))
      else $error("hazard without angle growth");

   // The input side stalls only when items are waiting in the queue.
   a_stall_queued: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_valid)
      else $error("input stalled with an empty queue");

endmodule

`default_nettype wire

/* src/angd_front.sv */
// ----------------------------------------------------------------------------
// angd_front
// Accepts input items, classifies them as sample, clear or ignored sample,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module angd_front #(
   parameter int SOURCES = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // [1:0] source, [33:2] time_ms, [50:34] angle, [55:51] zero
   input  wire logic [55:0]        req_tdata,
   // [0] command
   input  wire logic [0:0]         req_tuser,
   output logic                    q_valid,
   output angd_pkg::item_type      q_item,
   input  wire logic               q_pop
);

   angd_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   angd_pkg::item_type item_new;
   logic               push;

   // Classify the incoming item.
   always_comb begin
      item_new.source  = req_tdata[1:0];
      item_new.time_ms = req_tdata[33:2];
      item_new.angle   = $signed(req_tdata[50:34]);
      if (req_tuser[0] == angd_pkg::CMD_CLEAR) begin
         item_new.kind = angd_pkg::KIND_CLEAR;
      end else if (int'(req_tdata[1:0]) < SOURCES) begin
         item_new.kind = angd_pkg::KIND_SAMPLE;
      end else begin
         item_new.kind = angd_pkg::KIND_IGNORE;
      end
   end

   // Queue pointers and fill level.
   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !(q_pop && q_valid)) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && q_pop && q_valid) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

`default_nettype wire

/* src/angd_back.sv */
// ----------------------------------------------------------------------------
// angd_back
// Carries out one queued item at a time: ring update, drop of aged points,
// reference lookup, projection test and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module angd_back #(
   parameter int SOURCES       = 4,
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire angd_pkg::csr_type    csr,
   input  wire logic                 q_valid,
   input  wire angd_pkg::item_type   q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output angd_pkg::result_type      rsp
);

   localparam int SRC_W   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int POS_W   = $clog2(HISTORY_DEPTH);
   localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int ADDR_W  = SRC_W + POS_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic [POS_W:0]     DEPTH_EXT   = (POS_W+1)'(HISTORY_DEPTH);
   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(HISTORY_DEPTH);
   localparam logic [COUNT_W-1:0] TWO_COUNT   = COUNT_W'(2);

   // Ring position of head plus an offset, wrapped at the history depth.
   function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] head,
                                                 input logic [POS_W:0] offset);
      logic [POS_W:0] sum;
      sum = {1'b0, head} + offset;
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[POS_W-1:0];
   endfunction

   angd_pkg::back_state_type  state_ff, state_in;
   angd_pkg::item_type        item_ff, item_in;
   logic [POS_W-1:0]          head_ff  [SOURCES];
   logic [POS_W-1:0]          head_in  [SOURCES];
   logic [COUNT_W-1:0]        count_ff [SOURCES];
   logic [COUNT_W-1:0]        count_in [SOURCES];
   logic                      overflow_ff, overflow_in;
   logic signed [angd_pkg::ANGLE_W-1:0] ref_angle_ff, ref_angle_in;
   logic [angd_pkg::TIME_W-1:0]         span_ff, span_in;
   logic                      hazard_ff, hazard_in;
   logic [angd_pkg::LHS_W-1:0]          lhs_ff, lhs_in;
   logic signed [angd_pkg::RHS_W-1:0]   rhs_ff, rhs_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   angd_pkg::result_type      rsp_ff, rsp_in;

   // Point memory, one ring of HISTORY_DEPTH entries per source.
   angd_pkg::point_type       point_ram [MEM_DEPTH];
   angd_pkg::point_type       rd_point_ff;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   angd_pkg::point_type       wr_data;
   logic [ADDR_W-1:0]         rd_addr;

   logic [SRC_W-1:0]          sidx;
   logic [POS_W-1:0]          cur_head;
   logic [COUNT_W-1:0]        cur_count;
   logic                      ring_full;
   logic [POS_W-1:0]          head_d;
   logic [COUNT_W-1:0]        count_d;
   logic [angd_pkg::TIME_W-1:0]         age;
   logic signed [angd_pkg::ANGLE_W:0]   growth;
   logic signed [angd_pkg::ANGLE_W:0]   margin;

   assign sidx      = SRC_W'(item_ff.source);
   assign cur_head  = head_ff[sidx];
   assign cur_count = count_ff[sidx];
   assign ring_full = (cur_count == DEPTH_COUNT);
   assign head_d    = ring_full ? wrap_pos(cur_head, (POS_W+1)'(1)) : cur_head;
   assign count_d   = ring_full ? (cur_count - COUNT_W'(1)) : cur_count;
   assign age       = item_ff.time_ms - rd_point_ff.time_ms;
   assign growth    = (angd_pkg::ANGLE_W+1)'(item_ff.angle)
                      - (angd_pkg::ANGLE_W+1)'(ref_angle_ff);
   assign margin    = (angd_pkg::ANGLE_W+1)'(csr.critical_angle)
                      - (angd_pkg::ANGLE_W+1)'(item_ff.angle);

   // Sequencer: next state, ring bookkeeping and memory accesses.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      ref_angle_in = ref_angle_ff;
      span_in      = span_ff;
      hazard_in    = hazard_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;

      unique case (state_ff)
         angd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               item_in      = q_item;
               overflow_in  = 1'b0;
               ref_angle_in = q_item.angle;
               span_in      = '0;
               hazard_in    = 1'b0;
               unique case (q_item.kind)
                  angd_pkg::KIND_SAMPLE: state_in = angd_pkg::ST_APPEND;
                  angd_pkg::KIND_CLEAR: begin
                     for (int i = 0; i < SOURCES; i++) begin
                        head_in[i]  = '0;
                        count_in[i] = '0;
                     end
                     state_in = angd_pkg::ST_DONE;
                  end
                  default: state_in = angd_pkg::ST_DONE;
               endcase
            end
         end

         // Drop the oldest point of a full ring, then store the new one.
         angd_pkg::ST_APPEND: begin
            overflow_in    = ring_full;
            wr_en          = 1'b1;
            wr_addr        = {sidx, wrap_pos(head_d, (POS_W+1)'(count_d))};
            wr_data.time_ms = item_ff.time_ms;
            wr_data.angle   = item_ff.angle;
            head_in[sidx]  = head_d;
            count_in[sidx] = count_d + COUNT_W'(1);
            state_in       = angd_pkg::ST_CHECK;
         end

         // Fetch the second-oldest point while two or more are stored.
         angd_pkg::ST_CHECK: begin
            if (cur_count >= TWO_COUNT) begin
               rd_addr  = {sidx, wrap_pos(cur_head, (POS_W+1)'(1))};
               state_in = angd_pkg::ST_SECOND;
            end else begin
               state_in = angd_pkg::ST_DONE;
            end
         end

         // Drop the oldest point if the second-oldest has aged out.
         angd_pkg::ST_SECOND: begin
            if (age >= {16'b0, csr.reference_window_ms}) begin
               head_in[sidx]  = wrap_pos(cur_head, (POS_W+1)'(1));
               count_in[sidx] = cur_count - COUNT_W'(1);
               state_in       = angd_pkg::ST_CHECK;
            end else begin
               rd_addr  = {sidx, cur_head};
               state_in = angd_pkg::ST_REF;
            end
         end

         // The oldest point is the reference.
         angd_pkg::ST_REF: begin
            ref_angle_in = rd_point_ff.angle;
            span_in      = age;
            if (age >= {16'b0, csr.min_dt_ms} && item_ff.angle > rd_point_ff.angle) begin
               state_in = angd_pkg::ST_MUL;
            end else begin
               state_in = angd_pkg::ST_DONE;
            end
         end

         // Both sides of the projection test, registered.
         angd_pkg::ST_MUL: begin
            lhs_in   = {16'b0, growth[angd_pkg::ANGLE_W-1:0]} * {17'b0, csr.horizon_ms};
            rhs_in   = angd_pkg::RHS_W'(margin) * angd_pkg::RHS_W'($signed({1'b0, span_ff}));
            state_in = angd_pkg::ST_CMP;
         end

         angd_pkg::ST_CMP: begin
            hazard_in = ($signed({18'b0, lhs_ff}) >= rhs_ff);
            state_in  = angd_pkg::ST_DONE;
         end

         // Hand the result to the output register once it is free.
         angd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (item_ff.kind == angd_pkg::KIND_CLEAR) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.hazard           = hazard_ff;
                  rsp_in.hazard_source    = item_ff.source;
                  rsp_in.current_angle    = item_ff.angle;
                  rsp_in.reference_angle  = ref_angle_ff;
                  rsp_in.span_ms          = span_ff;
                  rsp_in.history_overflow = overflow_ff;
               end
               state_in = angd_pkg::ST_IDLE;
            end
         end

         default: state_in = angd_pkg::ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= angd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SOURCES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      overflow_ff  <= overflow_in;
      ref_angle_ff <= ref_angle_in;
      span_ff      <= span_in;
      hazard_ff    <= hazard_in;
      lhs_ff       <= lhs_in;
      rhs_ff       <= rhs_in;
      rsp_ff       <= rsp_in;
   end

   // Point memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_ram[wr_addr] <= wr_data;
      end
      rd_point_ff <= point_ram[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
